[rtl/core/lta_pkg.sv]
// Shared types and constants for the RGB565 lightness adjust core.
// No dependencies.
`default_nettype none

package lta_pkg;

  localparam int COLOR_W   = 16;
  localparam int CH_W      = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  // register reset values
  localparam logic [CFG_W-1:0] LUM_STEP_RST     = 8'd10;
  localparam logic [CFG_W-1:0] STEP_MIN_RST     = 8'd0;
  localparam logic [CFG_W-1:0] STEP_MAX_RST     = 8'd20;
  localparam logic [CFG_W-1:0] STEP_DEFAULT_RST = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LUM_STEP     = 2'd0,
    CFG_STEP_MIN     = 2'd1,
    CFG_STEP_MAX     = 2'd2,
    CFG_STEP_DEFAULT = 2'd3
  } cfg_idx_e;

  // segment of the HSL hue-to-channel curve
  typedef enum logic [1:0] {
    PIECE_RISE,
    PIECE_HIGH,
    PIECE_FALL,
    PIECE_LOW
  } piece_e;

endpackage

`default_nettype wire

[rtl/core/lta_div.sv]
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing valid and sideband. Depends on nothing.
`default_nettype none

module lta_div #(
  parameter int LANES = 1,
  parameter int XW    = 8,
  parameter int SH    = 0,
  parameter int DW    = 8,
  parameter int SBW   = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [XW-1:0]       x_i    [LANES],
  input  wire logic [DW-1:0]       den_i  [LANES],
  input  wire logic [SBW-1:0]      side_i,
  output logic                     valid_o,
  output logic [XW+SH-1:0]         quo_o  [LANES],
  output logic [DW-1:0]            rem_o  [LANES],
  output logic [SBW-1:0]           side_o
);

  localparam int NW = XW + SH;

  logic            vld_q  [NW];
  logic [SBW-1:0]  side_q [NW];
  logic [NW-1:0]   nq_q   [NW][LANES];
  logic [DW-1:0]   rem_q  [NW][LANES];
  logic [DW-1:0]   den_q  [NW][LANES];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic            vld_in;
    logic [SBW-1:0]  side_in;
    logic [NW-1:0]   nq_in  [LANES];
    logic [DW-1:0]   rem_in [LANES];
    logic [DW-1:0]   den_in [LANES];
    logic [DW:0]     trial  [LANES];
    logic            ge     [LANES];
    logic [NW-1:0]   nq_d   [LANES];
    logic [DW-1:0]   rem_d  [LANES];

    if (k == 0) begin : g_first
      always_comb begin
        vld_in  = valid_i;
        side_in = side_i;
        for (int l = 0; l < LANES; l++) begin
          nq_in[l]  = NW'(x_i[l]) << SH;
          rem_in[l] = '0;
          den_in[l] = den_i[l];
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in  = vld_q[k-1];
        side_in = side_q[k-1];
        for (int l = 0; l < LANES; l++) begin
          nq_in[l]  = nq_q[k-1][l];
          rem_in[l] = rem_q[k-1][l];
          den_in[l] = den_q[k-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_in[l], nq_in[l][NW-1]};
        ge[l]    = trial[l] >= {1'b0, den_in[l]};
        rem_d[l] = ge[l] ? DW'(trial[l] - {1'b0, den_in[l]}) : trial[l][DW-1:0];
        nq_d[l]  = {nq_in[l][NW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        for (int l = 0; l < LANES; l++) begin
          nq_q[k][l]  <= nq_d[l];
          rem_q[k][l] <= rem_d[l];
          den_q[k][l] <= den_in[l];
        end
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign side_o  = side_q[NW-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = nq_q[NW-1][l];
      rem_o[l] = rem_q[NW-1][l];
    end
  end

endmodule

`default_nettype wire

[rtl/core/lta_chan.sv]
// Hue-to-channel stage: one RGB channel from p, q and hue offset t, 4 stages.
// Depends on lta_pkg.
`default_nettype none

module lta_chan #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [FRAC_BITS:0]       p_i,
  input  wire logic [FRAC_BITS:0]       q_i,
  input  wire logic [FRAC_BITS:0]       t_i,
  output logic [lta_pkg::CH_W-1:0]      chan_o
);

  localparam int F  = FRAC_BITS;
  localparam int FW = F + 1;
  localparam logic [F:0] SIXTH      = FW'((1 << F) / 6);
  localparam logic [F:0] HALF       = FW'((1 << F) / 2);
  localparam logic [F:0] TWO_THIRDS = FW'((2 * (1 << F)) / 3);

  lta_pkg::piece_e mode_d, mode1_q, mode2_q;
  logic [F:0]      fac_d, fac1_q;
  logic [F:0]      dif1_q, p1_q, q1_q, p2_q, q2_q, v_d, v3_q;
  logic [F+2:0]    six_t, six_x;
  logic [F:0]      x_fall;
  logic [2*F+1:0]  prod2_q;
  logic [F+1:0]    vsum;
  logic [F+8:0]    v255;
  logic [8:0]      ch9;
  logic [lta_pkg::CH_W-1:0] ch_q;

  // segment select and slope factor
  always_comb begin
    six_t  = ({2'b0, t_i} << 2) + ({2'b0, t_i} << 1);
    x_fall = TWO_THIRDS - t_i;
    six_x  = ({2'b0, x_fall} << 2) + ({2'b0, x_fall} << 1);
    if (t_i < SIXTH) begin
      mode_d = lta_pkg::PIECE_RISE;
      fac_d  = six_t[F:0];
    end else if (t_i < HALF) begin
      mode_d = lta_pkg::PIECE_HIGH;
      fac_d  = '0;
    end else if (t_i < TWO_THIRDS) begin
      mode_d = lta_pkg::PIECE_FALL;
      fac_d  = six_x[F:0];
    end else begin
      mode_d = lta_pkg::PIECE_LOW;
      fac_d  = '0;
    end
  end

  always_comb begin
    vsum = {1'b0, p2_q} + prod2_q[2*F+1:F];
    case (mode2_q)
      lta_pkg::PIECE_RISE,
      lta_pkg::PIECE_FALL: v_d = vsum[F:0];
      lta_pkg::PIECE_HIGH: v_d = q2_q;
      default:             v_d = p2_q;
    endcase
    v255 = ({8'b0, v3_q} << 8) - {8'b0, v3_q};
    ch9  = v255[F+8:F];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q <= mode_d;
      fac1_q  <= fac_d;
      dif1_q  <= q_i - p_i;
      p1_q    <= p_i;
      q1_q    <= q_i;
      mode2_q <= mode1_q;
      prod2_q <= (2*F+2)'(dif1_q) * (2*F+2)'(fac1_q);
      p2_q    <= p1_q;
      q2_q    <= q1_q;
      v3_q    <= v_d;
      ch_q    <= ch9[8] ? 8'd255 : ch9[7:0];
    end
  end

  assign chan_o = ch_q;

endmodule

`default_nettype wire

[rtl/core/lta_skid.sv]
// Output register plus skid entry; parts pipeline advance from the
// receiver's stall. Depends on nothing.
`default_nettype none

module lta_skid #(
  parameter int DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic [DW-1:0] data_i,
  output logic               ready_o,
  output logic               valid_o,
  output logic [DW-1:0]      data_o,
  input  wire logic          stall_i
);

  logic          ov_q, sv_q;
  logic [DW-1:0] od_q, sd_q;
  logic          take, out_free;

  assign ready_o  = !sv_q;
  assign take     = valid_i && !sv_q;
  assign out_free = !ov_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (out_free) begin
      if (sv_q) begin
        ov_q <= 1'b1;
        sv_q <= 1'b0;
      end else begin
        ov_q <= take;
      end
    end else if (take) begin
      sv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      od_q <= sv_q ? sd_q : data_i;
    end else if (take) begin
      sd_q <= data_i;
    end
  end

  assign valid_o = ov_q;
  assign data_o  = od_q;

endmodule

`default_nettype wire

[rtl/core/rgb565_lightness_adjust_core.sv]
// RGB565 lightness adjust core: top level.
// Depends on lta_pkg, lta_div, lta_chan, lta_skid.
//
// Usage:
//  - Input channel in_valid_i / in_stall_o carries color_in_i. A transfer
//    happens on a rising edge with valid high and stall low.
//  - Output channel out_valid_o / out_stall_i carries color_out_o, same rule.
//  - Config channel cfg_valid_i / cfg_ready_o writes cfg_data_i into the
//    register named by cfg_index_i (lum_step, step_min, step_max,
//    step_default). Write only while the pipeline is empty.
//  - Throughput: one color per clock while the pipeline is not stalled
//    (in_stall_o low). The pipeline holds the two
//    bit-per-stage dividers (HSL conversion and lightness remap).
//  - One result per color, in order. Pass-through colors (step equal to
//    default, or empty step range) take the same path and latency.
//  - Receiver stall: the result holds in the output register, one more
//    result lands in the skid entry, then in_stall_o rises and the whole
//    pipeline freezes. in_stall_o is a register output.
//  - Reset: pipeline and output empty, registers back to 10/0/20/10.
`default_nettype none

module rgb565_lightness_adjust_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [lta_pkg::COLOR_W-1:0]       color_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [lta_pkg::COLOR_W-1:0]            color_out_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lta_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [lta_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int F   = FRAC_BITS;
  localparam int FW  = F + 1;
  localparam int CW  = lta_pkg::COLOR_W;
  localparam int AXW = 11;                 // HSL divider numerator/denominator
  localparam int NWA = AXW + F;
  localparam int SBA = FW + CW;
  localparam int BXW = F + 9;              // remap divider numerator
  localparam int SBW = FW + F + FW + F + 1 + CW;

  localparam logic [F:0] ONE   = FW'(1 << F);
  localparam logic [F:0] HALF  = FW'((1 << F) / 2);
  localparam logic [F:0] CAP   = FW'((3 * (1 << F)) / 10);
  localparam logic [F:0] THIRD = FW'((1 << F) / 3);
  // l = sum*ONE/510 = sum*2^(F-1)/255, exact as (sum*LMUL) >> 17 for 9-bit sum
  localparam logic [F+8:0] LMUL = (F+9)'(((longint'(1) << (F + 16)) + 254) / 255);

  // ---------------- configuration registers ----------------
  logic [7:0] lum_step_q, step_min_q, step_max_q, step_default_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lum_step_q     <= lta_pkg::LUM_STEP_RST;
      step_min_q     <= lta_pkg::STEP_MIN_RST;
      step_max_q     <= lta_pkg::STEP_MAX_RST;
      step_default_q <= lta_pkg::STEP_DEFAULT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lta_pkg::cfg_idx_e'(cfg_index_i))
        lta_pkg::CFG_LUM_STEP:     lum_step_q     <= cfg_data_i;
        lta_pkg::CFG_STEP_MIN:     step_min_q     <= cfg_data_i;
        lta_pkg::CFG_STEP_MAX:     step_max_q     <= cfg_data_i;
        lta_pkg::CFG_STEP_DEFAULT: step_default_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: whole pipeline moves while the skid entry is free
  logic en;
  assign in_stall_o = !en;

  // ---------------- RGB expand, max/min, lightness, hue numerator ----------------
  logic [7:0]        r8, g8, b8, mx, mn, dd;
  logic [8:0]        sum, sden;
  logic [10:0]       d6, hden;
  logic signed [11:0] nval;
  logic [F+17:0]     l_mul;
  logic [F:0]        l_in;
  logic [AXW-1:0]    ax   [2];
  logic [AXW-1:0]    aden [2];

  always_comb begin
    r8   = {color_in_i[15:11], 3'b0};
    g8   = {color_in_i[10:5], 2'b0};
    b8   = {color_in_i[4:0], 3'b0};
    mx   = (r8 > g8) ? r8 : g8;
    if (b8 > mx) mx = b8;
    mn   = (r8 < g8) ? r8 : g8;
    if (b8 < mn) mn = b8;
    dd   = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    l_mul = (F+18)'(sum) * (F+18)'(LMUL);
    l_in  = l_mul[F+17:17];
    d6   = ({3'b0, dd} << 2) + ({3'b0, dd} << 1);
    if (mx == r8) begin
      nval = $signed({4'b0, g8}) - $signed({4'b0, b8})
           + ((g8 < b8) ? $signed({1'b0, d6}) : 12'sd0);
    end else if (mx == g8) begin
      nval = $signed({4'b0, b8}) - $signed({4'b0, r8}) + $signed({2'b0, dd, 1'b0});
    end else begin
      nval = $signed({4'b0, r8}) - $signed({4'b0, g8}) + $signed({1'b0, dd, 2'b0});
    end
    sden = (sum > 9'd255) ? 9'd510 - sum : sum;
    if (sden == 9'd0) sden = 9'd1;      // gray: saturation forced to zero
    hden = (dd == 8'd0) ? 11'd1 : d6;
    ax[0]   = {3'b0, dd};
    ax[1]   = nval[10:0];
    aden[0] = {2'b0, sden};
    aden[1] = hden;
  end

  // ---------------- HSL divider: s, h; l rides along ----------------
  logic           a_vld;
  logic [NWA-1:0] a_quo [2];
  logic [AXW-1:0] a_rem [2];
  logic [SBA-1:0] a_side;
  logic [F:0]     a_l;
  logic [CW-1:0]  a_col;

  assign {a_l, a_col} = a_side;

  lta_div #(
    .LANES(2), .XW(AXW), .SH(F), .DW(AXW), .SBW(SBA)
  ) u_div_hsl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .x_i     (ax),
    .den_i   (aden),
    .side_i  ({l_in, color_in_i}),
    .valid_o (a_vld),
    .quo_o   (a_quo),
    .rem_o   (a_rem),
    .side_o  (a_side)
  );

  // ---------------- stage 2: lightness swing ----------------
  logic [F:0]   l_a, am;
  logic         v2_q;
  logic [CW-1:0] col2_q;
  logic [F:0]   l2_q, s2_q;
  logic [F-1:0] a2_q, h2_q;

  always_comb begin
    l_a = a_l;
    am  = (l_a < HALF) ? l_a : ONE - l_a;
    if (am > CAP) am = CAP;
  end

  // ---------------- stage 3: remap numerator ----------------
  logic signed [8:0] sdiff, sden_s;
  logic [7:0]        dmag, rmag;
  logic [BXW-1:0]    num_d;
  logic              v3_q, neg3_q;
  logic [CW-1:0]     col3_q;
  logic [F:0]        l3_q, s3_q;
  logic [F-1:0]      a3_q, h3_q;
  logic [BXW-1:0]    num3_q;

  always_comb begin
    sdiff  = $signed({1'b0, lum_step_q}) - $signed({1'b0, step_min_q});
    sden_s = $signed({1'b0, step_max_q}) - $signed({1'b0, step_min_q});
    dmag   = sdiff[8] ? 8'(-sdiff) : sdiff[7:0];
    rmag   = sden_s[8] ? 8'(-sden_s) : sden_s[7:0];
    if (rmag == 8'd0) rmag = 8'd1;       // empty range passes through anyway
    num_d  = BXW'(dmag) * BXW'({a2_q, 1'b0});
  end

  // ---------------- remap divider ----------------
  logic           b_vld;
  logic [BXW-1:0] b_x   [1];
  logic [7:0]     b_den [1];
  logic [BXW-1:0] b_quo [1];
  logic [7:0]     b_rem [1];
  logic [SBW-1:0] b_side;

  assign b_x[0]   = num3_q;
  assign b_den[0] = rmag;

  lta_div #(
    .LANES(1), .XW(BXW), .SH(0), .DW(8), .SBW(SBW)
  ) u_div_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .x_i     (b_x),
    .den_i   (b_den),
    .side_i  ({l3_q, a3_q, s3_q, h3_q, neg3_q, col3_q}),
    .valid_o (b_vld),
    .quo_o   (b_quo),
    .rem_o   (b_rem),
    .side_o  (b_side)
  );

  // ---------------- stage 4: new lightness, floor and saturate ----------------
  logic [F:0]          l_b, s_b;
  logic [F-1:0]        a_b, h_b;
  logic                neg_b;
  logic [CW-1:0]       col_b;
  logic [F+10:0]       qadj;
  logic signed [F+10:0] term, lns;
  logic [F:0]          ln_d;
  logic                v4_q;
  logic [CW-1:0]       col4_q;
  logic [F:0]          ln4_q, s4_q;
  logic [F-1:0]        h4_q;

  always_comb begin
    {l_b, a_b, s_b, h_b, neg_b, col_b} = b_side;
    qadj = {2'b0, b_quo[0]} + (F+11)'(neg_b && (b_rem[0] != 8'd0));
    term = neg_b ? -$signed(qadj) : $signed(qadj);
    lns  = $signed({10'b0, l_b}) - $signed({11'b0, a_b}) + term;
    if (lns < 0) begin
      ln_d = '0;
    end else if (lns > $signed({10'b0, ONE})) begin
      ln_d = ONE;
    end else begin
      ln_d = lns[F:0];
    end
  end

  // ---------------- stage 5: ln * s ----------------
  logic            v5_q;
  logic [CW-1:0]   col5_q;
  logic [F:0]      ln5_q, s5_q;
  logic [F-1:0]    h5_q;
  logic [2*F+1:0]  prod5_q;

  // ---------------- stage 6: p, q and hue offsets ----------------
  logic [F:0]   ls, q_d, p_d, tr_d, tb_d;
  logic [F+1:0] qw, pw, trw;
  logic         v6_q;
  logic [CW-1:0] col6_q;
  logic [F:0]   p6_q, q6_q, tr6_q, tg6_q, tb6_q;

  always_comb begin
    ls   = prod5_q[2*F:F];
    qw   = (ln5_q < HALF) ? {1'b0, ln5_q} + {1'b0, ls}
                          : {1'b0, ln5_q} + {1'b0, s5_q} - {1'b0, ls};
    q_d  = qw[F:0];
    pw   = {ln5_q, 1'b0} - {1'b0, q_d};
    p_d  = pw[F:0];
    trw  = {2'b0, h5_q} + {1'b0, THIRD};
    tr_d = (trw > {1'b0, ONE}) ? FW'(trw - {1'b0, ONE}) : trw[F:0];
    tb_d = ({1'b0, h5_q} < THIRD) ? {1'b0, h5_q} + ONE - THIRD : {1'b0, h5_q} - THIRD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v2_q <= a_vld;
      v3_q <= v2_q;
      v4_q <= b_vld;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col2_q  <= a_col;
      l2_q    <= l_a;
      a2_q    <= am[F-1:0];
      s2_q    <= a_quo[0][F:0];
      h2_q    <= a_quo[1][F-1:0];
      col3_q  <= col2_q;
      l3_q    <= l2_q;
      a3_q    <= a2_q;
      s3_q    <= s2_q;
      h3_q    <= h2_q;
      num3_q  <= num_d;
      neg3_q  <= sdiff[8] ^ sden_s[8];
      col4_q  <= col_b;
      ln4_q   <= ln_d;
      s4_q    <= s_b;
      h4_q    <= h_b;
      col5_q  <= col4_q;
      ln5_q   <= ln4_q;
      s5_q    <= s4_q;
      h5_q    <= h4_q;
      prod5_q <= (2*F+2)'(ln4_q) * (2*F+2)'(s4_q);
      col6_q  <= col5_q;
      p6_q    <= p_d;
      q6_q    <= q_d;
      tr6_q   <= tr_d;
      tg6_q   <= {1'b0, h5_q};
      tb6_q   <= tb_d;
    end
  end

  // ---------------- channel units, 4 stages each ----------------
  logic [lta_pkg::CH_W-1:0] rc, gc, bc;

  lta_chan #(.FRAC_BITS(F)) u_chan_r (
    .clk_i (clk_i), .en_i (en), .p_i (p6_q), .q_i (q6_q), .t_i (tr6_q), .chan_o (rc)
  );
  lta_chan #(.FRAC_BITS(F)) u_chan_g (
    .clk_i (clk_i), .en_i (en), .p_i (p6_q), .q_i (q6_q), .t_i (tg6_q), .chan_o (gc)
  );
  lta_chan #(.FRAC_BITS(F)) u_chan_b (
    .clk_i (clk_i), .en_i (en), .p_i (p6_q), .q_i (q6_q), .t_i (tb6_q), .chan_o (bc)
  );

  // valid and original color ride alongside the channel units
  logic          cv_q [4];
  logic [CW-1:0] cc_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) cv_q[i] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= v6_q;
      for (int i = 1; i < 4; i++) cv_q[i] <= cv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cc_q[0] <= col6_q;
      for (int i = 1; i < 4; i++) cc_q[i] <= cc_q[i-1];
    end
  end

  // ---------------- repack, pass-through, output ----------------
  logic          pass;
  logic [CW-1:0] res;

  assign pass = (lum_step_q == step_default_q) || (step_max_q == step_min_q);
  assign res  = pass ? cc_q[3] : {rc[7:3], gc[7:2], bc[7:3]};

  lta_skid #(.DW(CW)) u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv_q[3]),
    .data_i  (res),
    .ready_o (en),
    .valid_o (out_valid_o),
    .data_o  (color_out_o),
    .stall_i (out_stall_i)
  );

  // ---------------- assertions ----------------
  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid full without output held");

  // pipeline freezes only after a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without output stall");

  // frozen pipeline keeps its valid bits
  a_frozen_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(v6_q) && $stable(cv_q[3])))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
